/* rtl/lcs_pkg.sv */
// lcs_pkg: shared types, constants and the sigmoid/tanh/saturate helpers
// used by the lstm cell step block; no dependencies
package lcs_pkg;
   localparam int HIDDEN = 32;
   localparam int FRAC_BITS = 12;
   localparam int GATE_ROWS = 4 * HIDDEN;
   localparam int HW = $clog2(HIDDEN);
   localparam int RW = $clog2(GATE_ROWS);
   localparam int WDEPTH = GATE_ROWS * HIDDEN;
   localparam int WAW = $clog2(WDEPTH);
   localparam logic signed [19:0] FX_ONE = 20'sd1 <<< FRAC_BITS;

   typedef enum logic [2:0] {
      OP_WEIGHT = 3'd0,
      OP_BIAS   = 3'd1,
      OP_PROJ   = 3'd2,
      OP_STEP   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_MAC_ADDR, ST_MAC, ST_MAC_LAST, ST_ROW_END,
      ST_UNIT_RD, ST_UNIT_WAIT, ST_UNIT_IG, ST_UNIT_C1, ST_UNIT_C2, ST_UNIT_H,
      ST_UNIT_OUT
   } state_type;

   // piecewise linear sigmoid on an 18-bit signed value, result 0..one
   function automatic logic signed [19:0] sigm(input logic signed [17:0] x);
      logic signed [19:0] a;
      logic signed [19:0] y;
      a = x[17] ? -20'(x) : 20'(x);
      if (a >= 5 * FX_ONE) y = FX_ONE;
      else if (a >= (19 * FX_ONE) / 8) y = (a >>> 5) + (27 * FX_ONE) / 32;
      else if (a >= FX_ONE) y = (a >>> 3) + (5 * FX_ONE) / 8;
      else y = (a >>> 2) + FX_ONE / 2;
      return x[17] ? FX_ONE - y : y;
   endfunction

   // tanh as 2*sigmoid(2x)-one, 2x at full width
   function automatic logic signed [19:0] tanhf(input logic signed [15:0] x);
      logic signed [17:0] x2;
      x2 = 18'(x) <<< 1;
      return (sigm(x2) <<< 1) - FX_ONE;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sh7fff;
      if (v < -48'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage

/* rtl/lcs_ram.sv */
// lcs_ram: generic single port write, single read port ram, registered read
// no dependencies
module lcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/lstm_cell_step.sv */
// lstm_cell_step: top level, sequencer around one shared multiply unit
// depends on lcs_pkg and lcs_ram
//
// Usage: present an item on req_op/req_row/req_col/req_value with start high;
// it is taken at an edge where busy is low. Weight, bias and projection
// writes leave busy low, so the next word can follow at once. A clear
// item zeroes the hidden and cell stores, with busy high in the clear state
// that follows. A step item runs every gate row through one shared
// multiply-accumulate, one weight-times-hidden product a cycle within a row,
// with address and row-end states between rows; then each unit passes through
// the same multiplier for its cell and hidden values, and gives one word on
// the rsp_ ports, marked by rsp_valid for one cycle, rsp_last on the final
// unit. busy stays high until the last word has been shown. The receiver
// cannot stall: each word is shown once. Reset clears the hidden and cell
// stores and puts the sequencer in its clear state, with busy high. The
// weight, bias, projection and gate memories hold no reset value.
module lstm_cell_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_op,
   input  logic [6:0]           req_row,
   input  logic [4:0]           req_col,
   input  logic signed [15:0]   req_value,
   output logic                 rsp_valid,
   output logic [4:0]           rsp_unit,
   output logic signed [15:0]   rsp_hidden_value,
   output logic signed [15:0]   rsp_cell_value,
   output logic                 rsp_last
);
   import lcs_pkg::*;

   state_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [HW:0] col_ff, col_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [15:0] c_new_ff, c_new_in;
   logic signed [19:0] og_ff, og_in;
   logic signed [19:0] ig_ff, ig_in;
   logic rsp_valid_ff, rsp_valid_in;

   // hidden and cell stores, kept as small arrays
   logic signed [15:0] hid_ff [HIDDEN];
   logic signed [15:0] nh_ff [HIDDEN];
   logic signed [15:0] cel_ff [HIDDEN];

   // memories
   logic w_we, b_we, p_we;
   logic [WAW-1:0] w_waddr, w_raddr;
   logic [RW-1:0] bp_raddr;
   logic signed [15:0] w_rd, b_rd, p_rd;
   logic pre_we;
   logic [RW-1:0] pre_raddr;
   logic signed [15:0] pre_wdata, pre_rd;

   lcs_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(req_value),
      .rd_addr(w_raddr), .rd_data(w_rd));
   lcs_ram #(.WIDTH(16), .DEPTH(GATE_ROWS)) u_bram (
      .clock(clock), .wr_en(b_we), .wr_addr(req_row[RW-1:0]), .wr_data(req_value),
      .rd_addr(bp_raddr), .rd_data(b_rd));
   lcs_ram #(.WIDTH(16), .DEPTH(GATE_ROWS)) u_pram (
      .clock(clock), .wr_en(p_we), .wr_addr(req_row[RW-1:0]), .wr_data(req_value),
      .rd_addr(bp_raddr), .rd_data(p_rd));
   lcs_ram #(.WIDTH(16), .DEPTH(GATE_ROWS)) u_gram (
      .clock(clock), .wr_en(pre_we), .wr_addr(row_ff), .wr_data(pre_wdata),
      .rd_addr(pre_raddr), .rd_data(pre_rd));

   logic accept;
   logic row_ok, col_ok;
   assign accept = start && !busy;
   assign row_ok = 32'(req_row) < GATE_ROWS;
   assign col_ok = 32'(req_col) < HIDDEN;
   assign w_we = accept && req_op == OP_WEIGHT && row_ok && col_ok;
   assign b_we = accept && req_op == OP_BIAS && row_ok;
   assign p_we = accept && req_op == OP_PROJ && row_ok;
   assign w_waddr = WAW'(32'(req_row) * HIDDEN + 32'(req_col));
   assign w_raddr = WAW'(32'(row_ff) * HIDDEN + 32'(col_ff[HW-1:0]));
   assign bp_raddr = row_ff;

   // shared multiplier operands
   logic [HW-1:0] unit;
   logic [HW-1:0] mac_col;
   logic signed [19:0] ma, mb;
   logic signed [39:0] prod;
   logic signed [19:0] fg, gg, tc;
   assign unit = row_ff[HW-1:0];
   // read data is registered, so pair it with the previous column
   assign mac_col = col_ff[HW-1:0] - 1'b1;
   assign fg = sigm(18'(pre_rd));
   assign gg = tanhf(pre_rd);
   assign tc = tanhf(c_new_ff);

   // gate memory read address for the unit phase
   always_comb begin
      unique case (state_ff)
         ST_UNIT_RD:   pre_raddr = RW'(3 * HIDDEN + 32'(unit));
         ST_UNIT_WAIT: pre_raddr = RW'(32'(unit));
         ST_UNIT_IG:   pre_raddr = RW'(HIDDEN + 32'(unit));
         ST_UNIT_C1:   pre_raddr = RW'(2 * HIDDEN + 32'(unit));
         default:      pre_raddr = RW'(32'(unit));
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_UNIT_C1: begin ma = fg; mb = 20'(cel_ff[unit]); end
         ST_UNIT_C2: begin ma = ig_ff; mb = gg; end
         ST_UNIT_H:  begin ma = og_ff; mb = tc; end
         default:    begin ma = 20'(w_rd); mb = 20'(hid_ff[mac_col]); end
      endcase
   end
   assign prod = ma * mb;

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      acc_in = acc_ff;
      c_new_in = c_new_ff;
      og_in = og_ff;
      ig_in = ig_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_STEP) begin
               state_in = ST_MAC_ADDR; row_in = '0; col_in = '0; acc_in = '0;
            end else if (accept && req_op == OP_CLEAR) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: state_in = ST_IDLE;
         ST_MAC_ADDR: begin
            col_in = col_ff + 1'b1; state_in = ST_MAC;
         end
         ST_MAC: begin
            acc_in = acc_ff + 48'(prod);
            col_in = col_ff + 1'b1;
            if (32'(col_ff) == HIDDEN) state_in = ST_MAC_LAST;
         end
         ST_MAC_LAST: state_in = ST_ROW_END;
         ST_ROW_END: begin
            acc_in = '0; col_in = '0;
            if (32'(row_ff) == GATE_ROWS - 1) begin
               row_in = '0; state_in = ST_UNIT_RD;
            end else begin
               row_in = row_ff + 1'b1; state_in = ST_MAC_ADDR;
            end
         end
         ST_UNIT_RD: state_in = ST_UNIT_WAIT;
         ST_UNIT_WAIT: begin
            og_in = sigm(18'(pre_rd));
            state_in = ST_UNIT_IG;
         end
         ST_UNIT_IG: begin
            ig_in = sigm(18'(pre_rd));
            state_in = ST_UNIT_C1;
         end
         ST_UNIT_C1: begin acc_in = 48'(prod); state_in = ST_UNIT_C2; end
         ST_UNIT_C2: begin
            c_new_in = sat16((acc_ff + 48'(prod)) >>> FRAC_BITS);
            state_in = ST_UNIT_H;
         end
         ST_UNIT_H: begin
            acc_in = 48'(prod); rsp_valid_in = 1'b1; state_in = ST_UNIT_OUT;
         end
         ST_UNIT_OUT: begin
            if (32'(row_ff) == HIDDEN - 1) begin
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + 1'b1; state_in = ST_UNIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic signed [15:0] h_new;
   assign h_new = sat16(acc_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      og_ff <= og_in;
      ig_ff <= ig_in;
      c_new_ff <= c_new_in;
      acc_ff <= acc_in;
   end

   // gate pre-activation written at the end of each row
   logic signed [47:0] pre_sum;
   assign pre_sum = (acc_ff >>> FRAC_BITS) + 48'(p_rd) + 48'(b_rd);
   assign pre_we = state_ff == ST_ROW_END;
   assign pre_wdata = sat16(pre_sum);

   // stores: clear and unit updates
   always_ff @(posedge clock) begin
      if (reset || state_ff == ST_CLEAR) begin
         for (int k = 0; k < HIDDEN; k++) begin
            hid_ff[k] <= '0; cel_ff[k] <= '0;
         end
      end else begin
         if (state_ff == ST_UNIT_OUT) begin
            cel_ff[unit] <= c_new_ff;
            nh_ff[unit] <= rsp_hidden_value;
            if (32'(row_ff) == HIDDEN - 1) begin
               for (int k = 0; k < HIDDEN - 1; k++) hid_ff[k] <= nh_ff[k];
               hid_ff[HIDDEN - 1] <= rsp_hidden_value;
            end
         end
      end
   end

   // output word register
   logic signed [15:0] cel_out_ff;
   logic [4:0] unit_out_ff;
   logic last_out_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_UNIT_H) begin
         cel_out_ff <= c_new_ff;
         unit_out_ff <= 5'(row_ff);
         last_out_ff <= 32'(row_ff) == HIDDEN - 1;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hidden_value = h_new;
   assign rsp_cell_value = cel_out_ff;
   assign rsp_unit = unit_out_ff;
   assign rsp_last = last_out_ff;
   assign busy = state_ff != ST_IDLE;

   // checks
   a_rsp_in_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_UNIT_OUT) else $error("word outside unit phase");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy) else $error("busy after last word");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |=> busy) else $error("idle during mac pass");
endmodule

/* tb/lstm_cell_step_tb.sv */
// lstm_cell_step_tb: self-checking testbench for the lstm cell step block
// depends on lcs_pkg and the lstm_cell_step rtl; holds its own gate model
class lstm_scoreboard;
   typedef struct {
      logic [4:0]         unit;
      logic signed [15:0] hidden_value;
      logic signed [15:0] cell_value;
      logic               last;
   } unit_word;

   localparam longint ONE = longint'(1) << lcs_pkg::FRAC_BITS;

   longint   weight_mem [lcs_pkg::WDEPTH];
   longint   bias_mem [lcs_pkg::GATE_ROWS];
   longint   proj_mem [lcs_pkg::GATE_ROWS];
   longint   hid_mem [lcs_pkg::HIDDEN];
   longint   cell_mem [lcs_pkg::HIDDEN];
   unit_word expected_units[$];
   int       errors;

   function new();
      errors = 0;
      foreach (weight_mem[k]) weight_mem[k] = 0;
      foreach (bias_mem[k]) bias_mem[k] = 0;
      foreach (proj_mem[k]) proj_mem[k] = 0;
      foreach (hid_mem[k]) hid_mem[k] = 0;
      foreach (cell_mem[k]) cell_mem[k] = 0;
   endfunction

   function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // piecewise linear sigmoid, floors on the slope divisions
   function longint sigmoid_fx(longint x);
      longint a;
      longint y;
      a = (x < 0) ? -x : x;
      if (a >= 5 * ONE) y = ONE;
      else if (a >= (19 * ONE) / 8) y = (a >>> 5) + (27 * ONE) / 32;
      else if (a >= ONE) y = (a >>> 3) + (5 * ONE) / 8;
      else y = (a >>> 2) + ONE / 2;
      return (x < 0) ? ONE - y : y;
   endfunction

   function longint tanh_fx(longint x);
      return 2 * sigmoid_fx(2 * x) - ONE;
   endfunction

   function int pending();
      return expected_units.size();
   endfunction

   // update the model with one accepted word, queue any unit results
   function void note(logic [2:0] op, logic [6:0] row, logic [4:0] col,
                      logic signed [15:0] value);
      longint   pre [lcs_pkg::GATE_ROWS];
      longint   new_hid [lcs_pkg::HIDDEN];
      longint   acc;
      longint   ig, fg, gg, og, cn, hn;
      unit_word w;
      case (op)
         lcs_pkg::OP_WEIGHT: weight_mem[row * lcs_pkg::HIDDEN + col] = value;
         lcs_pkg::OP_BIAS:   bias_mem[row] = value;
         lcs_pkg::OP_PROJ:   proj_mem[row] = value;
         lcs_pkg::OP_CLEAR: begin
            foreach (hid_mem[k]) hid_mem[k] = 0;
            foreach (cell_mem[k]) cell_mem[k] = 0;
         end
         lcs_pkg::OP_STEP: begin
            // gate pre-activations from the old hidden state
            for (int r = 0; r < lcs_pkg::GATE_ROWS; r++) begin
               acc = 0;
               for (int j = 0; j < lcs_pkg::HIDDEN; j++)
                  acc += weight_mem[r * lcs_pkg::HIDDEN + j] * hid_mem[j];
               pre[r] = clip16((acc >>> lcs_pkg::FRAC_BITS) + proj_mem[r] + bias_mem[r]);
            end
            // per unit cell and hidden update
            for (int u = 0; u < lcs_pkg::HIDDEN; u++) begin
               ig = sigmoid_fx(pre[u]);
               fg = sigmoid_fx(pre[lcs_pkg::HIDDEN + u]);
               gg = tanh_fx(pre[2 * lcs_pkg::HIDDEN + u]);
               og = sigmoid_fx(pre[3 * lcs_pkg::HIDDEN + u]);
               cn = clip16((fg * cell_mem[u] + ig * gg) >>> lcs_pkg::FRAC_BITS);
               hn = clip16((og * tanh_fx(cn)) >>> lcs_pkg::FRAC_BITS);
               cell_mem[u] = cn;
               new_hid[u] = hn;
               w.unit = u[4:0];
               w.hidden_value = hn[15:0];
               w.cell_value = cn[15:0];
               w.last = (u == lcs_pkg::HIDDEN - 1);
               expected_units.push_back(w);
            end
            foreach (hid_mem[k]) hid_mem[k] = new_hid[k];
         end
         default: ;
      endcase
   endfunction

   // compare one shown word with the oldest expectation
   function void check(logic [4:0] unit, logic signed [15:0] hv,
                       logic signed [15:0] cv, logic last);
      unit_word w;
      if (expected_units.size() == 0) begin
         $error("unexpected result word: unit %0d", unit);
         errors++;
         return;
      end
      w = expected_units.pop_front();
      if (unit !== w.unit) begin
         $error("unit: expected %0d, actual %0d", w.unit, unit);
         errors++;
      end
      if (hv !== w.hidden_value) begin
         $error("hidden_value: expected %0d, actual %0d", w.hidden_value, hv);
         errors++;
      end
      if (cv !== w.cell_value) begin
         $error("cell_value: expected %0d, actual %0d", w.cell_value, cv);
         errors++;
      end
      if (last !== w.last) begin
         $error("last: expected %0d, actual %0d", w.last, last);
         errors++;
      end
   endfunction
endclass

module lstm_cell_step_tb;
   import lcs_pkg::*;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam int IDLE_LIMIT = 40000;
   localparam int RANDOM_WORDS = 140;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_op = '0;
   logic [6:0]         req_row = '0;
   logic [4:0]         req_col = '0;
   logic signed [15:0] req_value = '0;
   logic               rsp_valid;
   logic [4:0]         rsp_unit;
   logic signed [15:0] rsp_hidden_value;
   logic signed [15:0] rsp_cell_value;
   logic               rsp_last;
   int                 idle_cycles = 0;

   lstm_scoreboard sb = new();

   lstm_cell_step DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_unit(rsp_unit), .rsp_hidden_value(rsp_hidden_value),
      .rsp_cell_value(rsp_cell_value), .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   // result words are taken whenever shown
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_unit, rsp_hidden_value, rsp_cell_value, rsp_last);
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one word and hold it until taken
   task automatic send(input logic [2:0] op, input logic [6:0] row,
                       input logic [4:0] col, input logic signed [15:0] value);
      req_op <= op;
      req_row <= row;
      req_col <= col;
      req_value <= value;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(op, row, col, value);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_value(input bit narrow);
      if (narrow) return 16'($signed($urandom_range(0, 8191)) - 4096);
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_word();
      int k;
      k = $urandom_range(0, 99);
      if (k < 25)
         send(OP_WEIGHT, 7'($urandom), 5'($urandom), rand_value($urandom_range(0, 2) != 0));
      else if (k < 37)
         send(OP_BIAS, 7'($urandom), 5'($urandom), rand_value(1'($urandom_range(0, 1))));
      else if (k < 49)
         send(OP_PROJ, 7'($urandom), 5'($urandom), rand_value(1'($urandom_range(0, 1))));
      else if (k < 67)
         send(OP_STEP, 7'($urandom), 5'($urandom), rand_value(1'b0));
      else if (k < 72)
         send(OP_CLEAR, 7'($urandom), 5'($urandom), rand_value(1'b0));
      else if (k < 78)
         send(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), 7'($urandom),
              5'($urandom), rand_value(1'b0));
      else
         send(OP_WEIGHT, 7'($urandom), 5'($urandom), rand_value(1'b1));
   endtask

   initial begin
      int sent;
      int burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill every weight, bias and projection entry before any step
      for (int r = 0; r < GATE_ROWS; r++) begin
         for (int c = 0; c < HIDDEN; c++)
            send(OP_WEIGHT, 7'(r), 5'(c), rand_value(1'b1));
         send(OP_BIAS, 7'(r), 5'($urandom), rand_value(1'b1));
         send(OP_PROJ, 7'(r), 5'($urandom), rand_value(1'b1));
      end

      // directed: extremes, unused ops, clear and steps
      send(OP_STEP, 7'd0, 5'd0, 16'sd0);
      send(OP_STEP, 7'd127, 5'd31, -16'sd1);
      send(OP_WEIGHT, 7'd127, 5'd31, 16'sh7fff);
      send(OP_WEIGHT, 7'd0, 5'd0, 16'sh8000);
      send(OP_BIAS, 7'd0, 5'd0, 16'sh7fff);
      send(OP_BIAS, 7'd127, 5'd31, 16'sh8000);
      send(OP_PROJ, 7'd64, 5'd0, 16'sh7fff);
      send(OP_PROJ, 7'd96, 5'd0, 16'sh8000);
      for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
         send(3'(k), 7'h55, 5'h0a, 16'sh5a5a);
      send(OP_STEP, 7'd0, 5'd0, 16'sd0);
      send(OP_STEP, 7'd0, 5'd0, 16'sd0);
      send(OP_CLEAR, 7'h2a, 5'h15, 16'sh1234);
      send(OP_STEP, 7'd0, 5'd0, 16'sd0);
      drain();

      // random bursts, each followed by a full drain, a pause or nothing
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst && sent < RANDOM_WORDS; b++) begin
            random_word();
            sent++;
         end
         if ($urandom_range(0, 9) == 0 || sent == RANDOM_WORDS / 2) drain();
         else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
